// File: hw/rtl/pid_speed_loop_with_clamps_assert.svh
// ----------------------------------------------------------------------------
// pid speed loop assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef PID_SPEED_LOOP_WITH_CLAMPS_ASSERT_SVH
`define PID_SPEED_LOOP_WITH_CLAMPS_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define PSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same-cycle implication, checked every clock outside reset
`define PSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PSC_ASSERT(lbl, clk, rst, prop, msg)
`define PSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/pid_spd_pkg.sv
// ----------------------------------------------------------------------------
// pid speed loop package
// shared widths, register indexes and the configuration record
// ----------------------------------------------------------------------------
package pid_spd_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int GAIN_FRAC_DEF  = 8;
   localparam int GAIN_W         = 16;
   localparam int LIMIT_W        = 15;
   localparam int SUM_W          = 32;
   localparam int CSR_IDX_W      = 3;

   // register indexes of the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INT_GAIN   = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_OUT_LIMIT  = 3'd3,
      CSR_INT_LIMIT  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  int_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [LIMIT_W-1:0] output_limit;
      logic [LIMIT_W-1:0] integral_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:      16'd205,
      int_gain:       16'd82,
      deriv_gain:     16'd77,
      output_limit:   15'd10000,
      integral_limit: 15'd5000
   };

endpackage

// File: hw/rtl/pid_spd_err.sv
// ----------------------------------------------------------------------------
// pid speed loop error stage
// forms the error, its change and the saturating error sum, holds loop state
// ----------------------------------------------------------------------------
`include "pid_speed_loop_with_clamps_assert.svh"

module pid_spd_err #(
   parameter int DATA_WIDTH = pid_spd_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pid_spd_pkg::cfg_type                 cfg,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [DATA_WIDTH-1:0]         in_target,
   input  logic signed [DATA_WIDTH-1:0]         in_meas,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [DATA_WIDTH:0]           out_err,
   output logic signed [DATA_WIDTH+1:0]         out_derr,
   output logic signed [pid_spd_pkg::SUM_W-1:0] out_sum
);
   import pid_spd_pkg::*;

   localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

   logic                        adv;
   logic signed [DATA_WIDTH:0]  err;
   logic signed [SUM_W:0]       sum_wide;
   logic signed [SUM_W-1:0]     sum_sat;
   logic                        vld_ff, vld_in;
   logic signed [DATA_WIDTH:0]  prev_ff, prev_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic signed [DATA_WIDTH+1:0] derr_ff, derr_in;

   assign in_ready = !vld_ff || out_ready;
   assign adv      = in_valid && in_ready;

   // error and saturating sum
   always_comb begin
      err      = (DATA_WIDTH+1)'(in_target) - (DATA_WIDTH+1)'(in_meas);
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(err);
      if (sum_wide > SUM_MAX) begin
         sum_sat = SUM_MAX[SUM_W-1:0];
      end else if (sum_wide < SUM_MIN) begin
         sum_sat = SUM_MIN[SUM_W-1:0];
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // state moves with each item taken; prev_ff always holds the item in this stage
   always_comb begin
      vld_in  = in_ready ? in_valid : vld_ff;
      prev_in = prev_ff;
      sum_in  = sum_ff;
      derr_in = derr_ff;
      if (adv) begin
         prev_in = err;
         sum_in  = (cfg.int_gain != '0) ? sum_sat : '0;
         derr_in = (DATA_WIDTH+2)'(err) - (DATA_WIDTH+2)'(prev_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         prev_ff <= '0;
         sum_ff  <= '0;
      end else begin
         vld_ff  <= vld_in;
         prev_ff <= prev_in;
         sum_ff  <= sum_in;
      end
      derr_ff <= derr_in;
   end

   assign out_valid = vld_ff;
   assign out_err   = prev_ff;
   assign out_derr  = derr_ff;
   assign out_sum   = sum_ff;

   // zero integral gain leaves a cleared sum
   `PSC_ASSERT(a_sum_clear, clock, reset, (adv && cfg.int_gain == '0) |=> (sum_ff == '0), "sum not cleared")
   // a non-negative error never lowers the sum
   `PSC_ASSERT(a_sum_mono, clock, reset, (adv && cfg.int_gain != '0 && !err[DATA_WIDTH]) |=> (sum_ff >= $past(sum_ff)), "sum decreased on non-negative error")

endmodule

// File: hw/rtl/pid_spd_mul.sv
// ----------------------------------------------------------------------------
// pid speed loop product stage
// multiplies error, error sum and error change by their gains
// ----------------------------------------------------------------------------
module pid_spd_mul #(
   parameter int DATA_WIDTH = pid_spd_pkg::DATA_WIDTH_DEF,
   parameter int TERM_W     = 49
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pid_spd_pkg::cfg_type                 cfg,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [DATA_WIDTH:0]           in_err,
   input  logic signed [DATA_WIDTH+1:0]         in_derr,
   input  logic signed [pid_spd_pkg::SUM_W-1:0] in_sum,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [TERM_W-1:0]             out_p,
   output logic signed [TERM_W-1:0]             out_i,
   output logic signed [TERM_W-1:0]             out_d
);
   import pid_spd_pkg::*;

   logic signed [GAIN_W:0]  kp_s, ki_s, kd_s;
   logic                    adv;
   logic                    vld_ff, vld_in;
   logic signed [TERM_W-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;

   assign in_ready = !vld_ff || out_ready;
   assign adv      = in_valid && in_ready;

   // gains are unsigned, carried as positive signed operands
   assign kp_s = {1'b0, cfg.prop_gain};
   assign ki_s = {1'b0, cfg.int_gain};
   assign kd_s = {1'b0, cfg.deriv_gain};

   always_comb begin
      vld_in = in_ready ? in_valid : vld_ff;
      p_in   = p_ff;
      i_in   = i_ff;
      d_in   = d_ff;
      if (adv) begin
         p_in = TERM_W'(kp_s) * TERM_W'(in_err);
         i_in = TERM_W'(ki_s) * TERM_W'(in_sum);
         d_in = TERM_W'(kd_s) * TERM_W'(in_derr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      p_ff <= p_in;
      i_ff <= i_in;
      d_ff <= d_in;
   end

   assign out_valid = vld_ff;
   assign out_p     = p_ff;
   assign out_i     = i_ff;
   assign out_d     = d_ff;

endmodule

// File: hw/rtl/pid_spd_out.sv
// ----------------------------------------------------------------------------
// pid speed loop output stages
// integral clamp and term sum, then output clamp, rounding and result register
// ----------------------------------------------------------------------------
`include "pid_speed_loop_with_clamps_assert.svh"

module pid_spd_out #(
   parameter int DATA_WIDTH     = pid_spd_pkg::DATA_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pid_spd_pkg::GAIN_FRAC_DEF,
   parameter int TERM_W         = 49
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pid_spd_pkg::cfg_type        cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [TERM_W-1:0]    in_p,
   input  logic signed [TERM_W-1:0]    in_i,
   input  logic signed [TERM_W-1:0]    in_d,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [DATA_WIDTH-1:0]       out_drive
);
   import pid_spd_pkg::*;

   localparam int TOT_W = TERM_W + 2;
   localparam logic signed [TOT_W-1:0] HALF = (TOT_W'(1) << GAIN_FRAC_BITS) >> 1;

   logic                     adv3, adv4, s4_ready;
   logic signed [TERM_W-1:0] ilim_sh, i_cl;
   logic signed [TOT_W-1:0]  olim_sh, olim_x, tot_cl, rnd_full;
   logic                     v3_ff, v3_in;
   logic signed [TOT_W-1:0]  tot_ff, tot_in;
   logic                     vld_ff, vld_in;
   logic [DATA_WIDTH-1:0]    drive_ff, drive_in;

   assign s4_ready = !vld_ff || out_ready;
   assign in_ready = !v3_ff || s4_ready;
   assign adv3     = in_valid && in_ready;
   assign adv4     = v3_ff && s4_ready;

   // integral clamp, zero limit passes the term through
   always_comb begin
      ilim_sh = TERM_W'(cfg.integral_limit) << GAIN_FRAC_BITS;
      i_cl    = in_i;
      if (cfg.integral_limit != '0) begin
         if (in_i > ilim_sh) begin
            i_cl = ilim_sh;
         end else if (in_i < -ilim_sh) begin
            i_cl = -ilim_sh;
         end
      end
   end

   // term sum
   always_comb begin
      v3_in  = in_ready ? in_valid : v3_ff;
      tot_in = tot_ff;
      if (adv3) begin
         tot_in = TOT_W'(in_p) + TOT_W'(i_cl) + TOT_W'(in_d);
      end
   end

   // output clamp and round half up
   always_comb begin
      olim_sh = TOT_W'(cfg.output_limit) << GAIN_FRAC_BITS;
      olim_x  = TOT_W'(cfg.output_limit);
      if (tot_ff > olim_sh) begin
         tot_cl = olim_sh;
      end else if (tot_ff < -olim_sh) begin
         tot_cl = -olim_sh;
      end else begin
         tot_cl = tot_ff;
      end
      rnd_full = (tot_cl + HALF) >>> GAIN_FRAC_BITS;
      vld_in   = s4_ready ? v3_ff : vld_ff;
      drive_in = adv4 ? rnd_full[DATA_WIDTH-1:0] : drive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff  <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         v3_ff  <= v3_in;
         vld_ff <= vld_in;
      end
      tot_ff   <= tot_in;
      drive_ff <= drive_in;
   end

   assign out_valid = vld_ff;
   assign out_drive = drive_ff;

   // rounded drive stays inside the output limit
   `PSC_ASSERT_IMPL(a_drive_lim, clock, reset, v3_ff, (rnd_full <= olim_x && rnd_full >= -olim_x), "drive beyond output limit")
   // clamped integral term stays inside the integral limit
   `PSC_ASSERT_IMPL(a_int_lim, clock, reset, (in_valid && cfg.integral_limit != '0), (i_cl <= ilim_sh && i_cl >= -ilim_sh), "integral term beyond limit")

endmodule

// File: hw/rtl/pid_speed_loop_with_clamps.sv
// ----------------------------------------------------------------------------
// pid speed loop with clamps
// positional pid with saturating error sum, integral clamp and output clamp
// ----------------------------------------------------------------------------
// throughput: one request per cycle, set by the five-register pipeline
//   (input, error, product, sum, result); stalls only on rsp_tready low
// reset: clears all valid bits, previous error and error sum, and loads the
//   gain and limit registers with their default values
module pid_speed_loop_with_clamps #(
   parameter int DATA_WIDTH     = pid_spd_pkg::DATA_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = pid_spd_pkg::GAIN_FRAC_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [pid_spd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pid_spd_pkg::GAIN_W-1:0]        csr_wdata,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // target_speed, measured_speed
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // drive
   output logic [((DATA_WIDTH+7)/8)*8-1:0]       rsp_tdata
);
   import pid_spd_pkg::*;

   localparam int RSP_W  = ((DATA_WIDTH+7)/8)*8;
   localparam int TERM_W = (DATA_WIDTH + 19 > 49) ? DATA_WIDTH + 19 : 49;

   cfg_type                       cfg_ff, cfg_in;
   logic                          req_vld_ff, req_vld_in;
   logic signed [DATA_WIDTH-1:0]  tgt_ff, tgt_in, meas_ff, meas_in;
   logic                          e_ready, e_valid, m_ready, m_valid, o_ready;
   logic signed [DATA_WIDTH:0]    e_err;
   logic signed [DATA_WIDTH+1:0]  e_derr;
   logic signed [SUM_W-1:0]       e_sum;
   logic signed [TERM_W-1:0]      m_p, m_i, m_d;
   logic [DATA_WIDTH-1:0]         drive;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:  cfg_in.prop_gain      = csr_wdata;
            CSR_INT_GAIN:   cfg_in.int_gain       = csr_wdata;
            CSR_DERIV_GAIN: cfg_in.deriv_gain     = csr_wdata;
            CSR_OUT_LIMIT:  cfg_in.output_limit   = csr_wdata[LIMIT_W-1:0];
            CSR_INT_LIMIT:  cfg_in.integral_limit = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // request register
   assign req_tready = !req_vld_ff || e_ready;

   always_comb begin
      req_vld_in = req_tready ? req_tvalid : req_vld_ff;
      tgt_in     = tgt_ff;
      meas_in    = meas_ff;
      if (req_tvalid && req_tready) begin
         tgt_in  = req_tdata[DATA_WIDTH-1:0];
         meas_in = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= CFG_RESET;
         req_vld_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         req_vld_ff <= req_vld_in;
      end
      tgt_ff  <= tgt_in;
      meas_ff <= meas_in;
   end

   pid_spd_err #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_err (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_vld_ff),
      .in_ready  (e_ready),
      .in_target (tgt_ff),
      .in_meas   (meas_ff),
      .out_valid (e_valid),
      .out_ready (m_ready),
      .out_err   (e_err),
      .out_derr  (e_derr),
      .out_sum   (e_sum)
   );

   pid_spd_mul #(
      .DATA_WIDTH (DATA_WIDTH),
      .TERM_W     (TERM_W)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (e_valid),
      .in_ready  (m_ready),
      .in_err    (e_err),
      .in_derr   (e_derr),
      .in_sum    (e_sum),
      .out_valid (m_valid),
      .out_ready (o_ready),
      .out_p     (m_p),
      .out_i     (m_i),
      .out_d     (m_d)
   );

   pid_spd_out #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .TERM_W         (TERM_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (m_valid),
      .in_ready  (o_ready),
      .in_p      (m_p),
      .in_i      (m_i),
      .in_d      (m_d),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_drive (drive)
   );

   assign rsp_tdata = RSP_W'(drive);

endmodule
